@@ rtl/nrmc_pkg.sv @@
// Shared constants and types for the NMEA RMC sentence parser.
// Used by every module of the block; has no dependencies of its own.
package nrmc_pkg;

    // Characters stored per field before further characters count as overflow.
    localparam int FIELD_CHARS = 16;

    // The position counter must be able to hold FIELD_CHARS itself (saturation).
    localparam int POS_W = $clog2(FIELD_CHARS + 1);

    // Widths of the payload fields.
    localparam int BYTE_W     = 8;
    localparam int FIELD_W    = 4;
    localparam int CHAR_POS_W = 4;

    // Characters that steer the parser.
    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_R      = 8'h52;
    localparam logic [BYTE_W-1:0] CH_M      = 8'h4D;
    localparam logic [BYTE_W-1:0] CH_C      = 8'h43;

    // Field numbering: the ninth field is the last one written, and the
    // counter stops one beyond it.
    localparam logic [FIELD_W-1:0] LAST_FIELD = 4'd8;
    localparam logic [FIELD_W-1:0] FIELD_SAT  = 4'd9;

    // One result word: a character write into the record.
    typedef struct packed {
        logic [FIELD_W-1:0]    field_index;
        logic [CHAR_POS_W-1:0] char_position;
        logic [BYTE_W-1:0]     char_value;
        logic                  sentence_done;
    } t_result;

endpackage

@@ rtl/nrmc_in_reg.sv @@
// Input register of the NMEA RMC parser: holds one received byte.
// Depends on nrmc_pkg.
module nrmc_in_reg
    import nrmc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic              i_step,
    output logic              o_full,
    output logic [BYTE_W-1:0] o_byte
);

    logic              r_full;
    logic [BYTE_W-1:0] r_byte;

    // A held word that cannot move on blocks the next one.
    assign o_stall = r_full && !i_step;

    // Load a new word whenever the register is free or being emptied.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else begin
            r_full <= o_stall ? 1'b1 : i_valid;
        end
        if (i_valid && !o_stall) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_full = r_full;
    assign o_byte = r_byte;

endmodule

@@ rtl/nrmc_core.sv @@
// Header state machine and field parser of the NMEA RMC parser.
// Consumes one byte per step and forms at most one result word. Depends on nrmc_pkg.
module nrmc_core
    import nrmc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_res_valid,
    output t_result           o_res
);

    typedef enum logic [3:0] {
        S_SYNC   = 4'd0,
        S_TALK0  = 4'd1,
        S_TALK1  = 4'd2,
        S_TYPE0  = 4'd3,
        S_TYPE1  = 4'd4,
        S_TYPE2  = 4'd5,
        S_DECIDE = 4'd6,
        S_FIELDS = 4'd7,
        S_WAIT   = 4'd8
    } t_state;

    t_state             r_state, n_state, eff_state;
    logic [BYTE_W-1:0]  r_type0, r_type1, r_type2;
    logic [BYTE_W-1:0]  n_type0, n_type1, n_type2;
    logic [FIELD_W-1:0] r_field, n_field;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic               type_rmc;

    assign type_rmc = (r_type0 == CH_R) && (r_type1 == CH_M) && (r_type2 == CH_C);

    // A dollar sign restarts the header from any state.
    assign eff_state = (i_byte == CH_DOLLAR) ? S_SYNC : r_state;

    // Next state and the result word for the current byte.
    always_comb begin
        n_state     = eff_state;
        n_type0     = r_type0;
        n_type1     = r_type1;
        n_type2     = r_type2;
        n_field     = r_field;
        n_pos       = r_pos;
        o_res_valid = 1'b0;
        o_res.field_index   = r_field;
        o_res.char_position = CHAR_POS_W'(r_pos);
        o_res.char_value    = i_byte;
        o_res.sentence_done = (r_field == LAST_FIELD);
        unique case (eff_state)
            S_SYNC:  n_state = S_TALK0;
            S_TALK0: n_state = S_TALK1;
            S_TALK1: n_state = S_TYPE0;
            S_TYPE0: begin
                n_type0 = i_byte;
                n_state = S_TYPE1;
            end
            S_TYPE1: begin
                n_type1 = i_byte;
                n_state = S_TYPE2;
            end
            S_TYPE2: begin
                n_type2 = i_byte;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (type_rmc) begin
                    n_state = S_FIELDS;
                    n_field = '0;
                    n_pos   = '0;
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_FIELDS: begin
                if (i_byte == CH_COMMA) begin
                    n_pos = '0;
                    if (r_field < FIELD_SAT) begin
                        n_field = r_field + 1'b1;
                    end
                end else if ((r_field <= LAST_FIELD) && (r_pos < POS_W'(FIELD_CHARS))) begin
                    // Bytes past the ninth field or past capacity are dropped.
                    o_res_valid = 1'b1;
                    n_pos       = r_pos + 1'b1;
                end
            end
            default: n_state = S_WAIT;
        endcase
    end

    // State registers advance once per consumed byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SYNC;
            r_type0 <= '0;
            r_type1 <= '0;
            r_type2 <= '0;
            r_field <= '0;
            r_pos   <= '0;
        end else if (i_step) begin
            r_state <= n_state;
            r_type0 <= n_type0;
            r_type1 <= n_type1;
            r_type2 <= n_type2;
            r_field <= n_field;
            r_pos   <= n_pos;
        end
    end

endmodule

@@ rtl/nrmc_out_reg.sv @@
// Result register of the NMEA RMC parser: holds one character write until taken.
// Depends on nrmc_pkg.
module nrmc_out_reg
    import nrmc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load_valid,
    input  logic    i_res_valid,
    input  t_result i_res,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // The register takes a new word when empty or when its word leaves now.
    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load_valid && i_res_valid;
        end
        if (o_ready) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

@@ rtl/nmea_rmc_sentence_parser_top.sv @@
// NMEA RMC sentence parser: one received byte in, at most one character write out.
// A byte is held in the input register and its write in the result register.
// Throughput: one byte per cycle while the output port is not stalled.
// Reset (i_rst_n low, synchronous): header returns to sync, counters and
// type letters clear, both internal registers empty.
module nmea_rmc_sentence_parser_top
    import nrmc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [BYTE_W-1:0]     i_rx_byte,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [FIELD_W-1:0]    o_field_index,
    output logic [CHAR_POS_W-1:0] o_char_position,
    output logic [BYTE_W-1:0]     o_char_value,
    output logic                  o_sentence_done
);

    logic              in_full;
    logic [BYTE_W-1:0] in_byte;
    logic              out_ready;
    logic              step;
    logic              res_valid;
    t_result           res;
    t_result           out_res;

    // A held byte is processed whenever the result register can take its word.
    assign step = in_full && out_ready;

    nrmc_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_rx_byte (i_rx_byte),
        .i_step    (step),
        .o_full    (in_full),
        .o_byte    (in_byte)
    );

    nrmc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    nrmc_out_reg u_out_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (in_full),
        .i_res_valid  (res_valid),
        .i_res        (res),
        .o_ready      (out_ready),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_res        (out_res)
    );

    assign o_field_index   = out_res.field_index;
    assign o_char_position = out_res.char_position;
    assign o_char_value    = out_res.char_value;
    assign o_sentence_done = out_res.sentence_done;

endmodule

@@ rtl/nrmc_checker.sv @@
// Port-level checks for the NMEA RMC parser, bound to the top level.
// Depends on nrmc_pkg and nmea_rmc_sentence_parser_top.
module nrmc_checker
    import nrmc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_stall,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [FIELD_W-1:0]    o_field_index,
    input logic [CHAR_POS_W-1:0] o_char_position,
    input logic [BYTE_W-1:0]     o_char_value,
    input logic                  o_sentence_done
);

    // A stalled word stays on the port.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_char_value)
                               && $stable(o_char_position))
        else $error("output word dropped or changed while stalled");

    // The parser only pushes back when its result register is blocked.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while output is free");

    // Writes never go past the ninth field.
    a_field_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_field_index <= LAST_FIELD)
        else $error("write to a field beyond the ninth");

    // The done flag marks exactly the writes into the ninth field.
    a_done_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sentence_done == (o_field_index == LAST_FIELD)))
        else $error("sentence_done does not match field index");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind nmea_rmc_sentence_parser_top nrmc_checker u_nrmc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_field_index   (o_field_index),
    .o_char_position (o_char_position),
    .o_char_value    (o_char_value),
    .o_sentence_done (o_sentence_done)
);
